// ===== hw/rtl/wbd_pkg.sv =====
package wbd_pkg;

   localparam int HEADER_BYTES = 32;
   localparam int POS_W = $clog2(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

   localparam logic [31:0] SIZE_BIAS = 32'd24;
   localparam int FINAL_BIT = 12;
   localparam int MONO_BIT = 2;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SYNC  = 2'd1;
   localparam logic [1:0] ERR_SHORT = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [47:0] new_pts;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [1:0]  byte_kind;
      logic        packet_start;
      logic        packet_end;
      logic [47:0] packet_pts;
      logic [31:0] packet_duration;
      logic [17:0] sample_rate;
      logic [5:0]  sample_bits;
      logic [7:0]  channel_total;
      logic [1:0]  error;
   } rsp_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = 8'h77;
         2'd1:    m = 8'h76;
         2'd2:    m = 8'h70;
         default: m = 8'h6b;
      endcase
      return m;
   endfunction

   function automatic logic [17:0] rate_lookup(input logic [3:0] code);
      logic [17:0] r;
      case (code)
         4'd0:    r = 18'd6000;
         4'd1:    r = 18'd8000;
         4'd2:    r = 18'd9600;
         4'd3:    r = 18'd11025;
         4'd4:    r = 18'd12000;
         4'd5:    r = 18'd16000;
         4'd6:    r = 18'd22050;
         4'd7:    r = 18'd24000;
         4'd8:    r = 18'd32000;
         4'd9:    r = 18'd44100;
         4'd10:   r = 18'd48000;
         4'd11:   r = 18'd64000;
         4'd12:   r = 18'd88200;
         4'd13:   r = 18'd96000;
         4'd14:   r = 18'd192000;
         default: r = 18'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/wavpack_block_deframer.sv =====
// Byte-stream deframer for WavPack block streams.
// req channel: one transfer per stream byte (cmd = 0) or a restart (cmd = 1)
// that clears framing and the sticky error and loads new_pts.
// rsp channel: exactly one transfer per req transfer, in order. Each carries
// the byte tagged as header, payload or discarded, packet start and end
// marks, and on packet end the packet pts, duration, sample rate, sample
// bits and channel total.
// The result is registered and shows on rsp in the cycle after the req
// transfer. Throughput: one byte per cycle while the receiver takes each
// result; all framing updates are done by the counters and byte compares
// between the req port and the result register.
// Reset clears framing state, the error and the pts (to 0); rsp_valid drops.
// When the receiver stalls, the result register holds and req_ready stays
// low until the held result is taken; a result taken in the same cycle
// frees the register for the next byte.
module wavpack_block_deframer
   import wbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [POS_W-1:0] header_pos_ff, header_pos_in;
   logic             in_payload_ff, in_payload_in;
   logic [31:0]      payload_left_ff, payload_left_in;
   logic [31:0]      block_length_ff, block_length_in;
   logic [31:0]      block_flags_ff, block_flags_in;
   logic             first_block_ff, first_block_in;
   logic [47:0]      running_pts_ff, running_pts_in;
   logic [31:0]      held_duration_ff, held_duration_in;
   logic [5:0]       held_format_ff, held_format_in;
   logic [7:0]       channel_sum_ff, channel_sum_in;
   logic [1:0]       error_state_ff, error_state_in;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_in;

   logic             accept;
   logic [POS_W-1:0] pos;
   logic [7:0]       b;
   logic             block_done;
   logic [8:0]       chan_wide;
   logic [2:0]       bits_code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pos       = header_pos_ff;
   assign b         = req_data.data_byte;

   always_comb begin
      header_pos_in    = header_pos_ff;
      in_payload_in    = in_payload_ff;
      payload_left_in  = payload_left_ff;
      block_length_in  = block_length_ff;
      block_flags_in   = block_flags_ff;
      first_block_in   = first_block_ff;
      running_pts_in   = running_pts_ff;
      held_duration_in = held_duration_ff;
      held_format_in   = held_format_ff;
      channel_sum_in   = channel_sum_ff;
      error_state_in   = error_state_ff;
      block_done       = 1'b0;
      chan_wide        = '0;
      bits_code        = '0;

      rsp_in              = '0;
      rsp_in.byte_out     = b;
      rsp_in.byte_kind    = KIND_NONE;

      if (req_data.cmd == CMD_RESTART) begin
         header_pos_in    = '0;
         in_payload_in    = 1'b0;
         payload_left_in  = '0;
         block_length_in  = '0;
         block_flags_in   = '0;
         first_block_in   = 1'b1;
         held_duration_in = '0;
         held_format_in   = '0;
         channel_sum_in   = '0;
         error_state_in   = ERR_NONE;
         running_pts_in   = req_data.new_pts;
         rsp_in.byte_out  = '0;
      end else if (error_state_ff != ERR_NONE) begin
         rsp_in.byte_kind = KIND_NONE;
      end else if (in_payload_ff) begin
         rsp_in.byte_kind = KIND_PAYLOAD;
         payload_left_in  = payload_left_ff - 32'd1;
         if (payload_left_in == '0) begin
            in_payload_in = 1'b0;
            block_done    = 1'b1;
         end
      end else if (first_block_ff && pos < POS_W'(4) && b != magic_byte(pos[1:0])) begin
         error_state_in = ERR_SYNC;
      end else begin
         if (pos >= POS_W'(4) && pos <= POS_W'(7)) begin
            if (pos == POS_W'(4)) begin
               block_length_in = {24'd0, b};
            end else begin
               block_length_in[{pos[1:0], 3'b000} +: 8] = b;
            end
         end
         if (pos == POS_W'(7) && block_length_in < SIZE_BIAS) begin
            error_state_in = ERR_SHORT;
         end else begin
            if (pos >= POS_W'(20) && pos <= POS_W'(23) && first_block_ff) begin
               if (pos == POS_W'(20)) begin
                  held_duration_in = {24'd0, b};
               end else begin
                  held_duration_in[{pos[1:0], 3'b000} +: 8] = b;
               end
            end
            if (pos >= POS_W'(24) && pos <= POS_W'(27)) begin
               if (pos == POS_W'(24)) begin
                  block_flags_in = {24'd0, b};
               end else begin
                  block_flags_in[{pos[1:0], 3'b000} +: 8] = b;
               end
               if (pos == POS_W'(27)) begin
                  if (first_block_ff) begin
                     held_format_in = {block_flags_in[1:0], block_flags_in[26:23]};
                  end
                  chan_wide = {1'b0, channel_sum_ff}
                            + (block_flags_in[MONO_BIT] ? 9'd1 : 9'd2);
                  channel_sum_in = chan_wide[8] ? 8'hff : chan_wide[7:0];
               end
            end
            rsp_in.byte_kind    = KIND_HEADER;
            rsp_in.packet_start = (pos == '0) && first_block_ff;
            if (pos == POS_LAST) begin
               header_pos_in   = '0;
               payload_left_in = block_length_ff - SIZE_BIAS;
               if (payload_left_in == '0) begin
                  block_done = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
               end
            end else begin
               header_pos_in = pos + POS_W'(1);
            end
         end
      end

      if (block_done) begin
         if (block_flags_ff[FINAL_BIT]) begin
            bits_code              = {1'b0, held_format_ff[5:4]} + 3'd1;
            rsp_in.packet_end      = 1'b1;
            rsp_in.packet_pts      = running_pts_ff;
            rsp_in.packet_duration = held_duration_ff;
            rsp_in.sample_rate     = rate_lookup(held_format_ff[3:0]);
            rsp_in.sample_bits     = {bits_code, 3'b000};
            rsp_in.channel_total   = channel_sum_ff;
            running_pts_in         = running_pts_ff + {16'd0, held_duration_ff};
            first_block_in         = 1'b1;
            channel_sum_in         = '0;
         end else begin
            first_block_in = 1'b0;
         end
      end

      rsp_in.error = error_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff    <= '0;
         in_payload_ff    <= 1'b0;
         payload_left_ff  <= '0;
         block_length_ff  <= '0;
         block_flags_ff   <= '0;
         first_block_ff   <= 1'b1;
         running_pts_ff   <= '0;
         held_duration_ff <= '0;
         held_format_ff   <= '0;
         channel_sum_ff   <= '0;
         error_state_ff   <= ERR_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            header_pos_ff    <= header_pos_in;
            in_payload_ff    <= in_payload_in;
            payload_left_ff  <= payload_left_in;
            block_length_ff  <= block_length_in;
            block_flags_ff   <= block_flags_in;
            first_block_ff   <= first_block_in;
            running_pts_ff   <= running_pts_in;
            held_duration_ff <= held_duration_in;
            held_format_ff   <= held_format_in;
            channel_sum_ff   <= channel_sum_in;
            error_state_ff   <= error_state_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   a_end_not_discard: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.packet_end |-> rsp_data_ff.byte_kind != KIND_NONE)
      else $error("packet end on a discarded byte");

   a_start_is_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.packet_start |->
         rsp_data_ff.byte_kind == KIND_HEADER && header_pos_ff == POS_W'(1))
      else $error("packet start not on first header byte");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> payload_left_ff != '0 && header_pos_ff == '0)
      else $error("payload state with nothing left");

   a_restart_loads: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.cmd == CMD_RESTART |=>
         error_state_ff == ERR_NONE && running_pts_ff == $past(req_data.new_pts))
      else $error("restart did not load pts or clear error");

endmodule

// ===== verif/wbd_deframe_checker.sv =====
module wbd_deframe_checker
   import wbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] SYNC_WORD = 32'h6b70_7677;
   localparam logic [16*18-1:0] RATE_HZ = {
      18'd0, 18'd192000, 18'd96000, 18'd88200, 18'd64000, 18'd48000, 18'd44100, 18'd32000,
      18'd24000, 18'd22050, 18'd16000, 18'd12000, 18'd11025, 18'd9600, 18'd8000, 18'd6000
   };

   logic [4:0]  hdr_idx;
   logic        in_body;
   logic [31:0] body_left;
   logic [31:0] blk_size;
   logic [31:0] blk_flags;
   logic        at_head;
   logic [47:0] pts_now;
   logic [31:0] pkt_samples;
   logic [5:0]  pkt_fmt;
   logic [7:0]  chan_count;
   logic [1:0]  sticky_err;

   rsp_type expected_rsp [$];
   rsp_type predicted;
   rsp_type oldest;

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      if (fail_count < 40)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task clear_framing();
      hdr_idx     = '0;
      in_body     = 1'b0;
      body_left   = '0;
      blk_size    = '0;
      blk_flags   = '0;
      at_head     = 1'b1;
      pkt_samples = '0;
      pkt_fmt     = '0;
      chan_count  = '0;
      sticky_err  = ERR_NONE;
   endtask

   task close_block(inout rsp_type o);
      if (blk_flags[FINAL_BIT]) begin
         o.packet_end      = 1'b1;
         o.packet_pts      = pts_now;
         o.packet_duration = pkt_samples;
         o.sample_rate     = RATE_HZ[pkt_fmt[3:0] * 18 +: 18];
         o.sample_bits     = ({4'd0, pkt_fmt[5:4]} + 6'd1) * 6'd8;
         o.channel_total   = chan_count;
         pts_now           = pts_now + {16'd0, pkt_samples};
         at_head           = 1'b1;
         chan_count        = '0;
      end else begin
         at_head = 1'b0;
      end
   endtask

   task take_header_byte(input logic [7:0] b, inout rsp_type o);
      int sh;
      logic [8:0] chan_next;
      sh = 8 * hdr_idx[1:0];
      if (at_head && hdr_idx < 5'd4 && b != SYNC_WORD[sh +: 8]) begin
         sticky_err  = ERR_SYNC;
         o.byte_kind = KIND_NONE;
      end else begin
         if (hdr_idx >= 5'd4 && hdr_idx <= 5'd7) begin
            if (hdr_idx == 5'd4)
               blk_size = {24'd0, b};
            else
               blk_size[sh +: 8] = b;
         end
         if (hdr_idx == 5'd7 && blk_size < SIZE_BIAS) begin
            sticky_err  = ERR_SHORT;
            o.byte_kind = KIND_NONE;
         end else begin
            if (hdr_idx >= 5'd20 && hdr_idx <= 5'd23 && at_head) begin
               if (hdr_idx == 5'd20)
                  pkt_samples = {24'd0, b};
               else
                  pkt_samples[sh +: 8] = b;
            end
            if (hdr_idx >= 5'd24 && hdr_idx <= 5'd27) begin
               if (hdr_idx == 5'd24)
                  blk_flags = {24'd0, b};
               else
                  blk_flags[sh +: 8] = b;
               if (hdr_idx == 5'd27) begin
                  if (at_head)
                     pkt_fmt = {blk_flags[1:0], blk_flags[26:23]};
                  chan_next = {1'b0, chan_count} + (blk_flags[MONO_BIT] ? 9'd1 : 9'd2);
                  chan_count = (chan_next > 9'd255) ? 8'd255 : chan_next[7:0];
               end
            end
            o.byte_kind    = KIND_HEADER;
            o.packet_start = (hdr_idx == 5'd0) && at_head;
            if (hdr_idx == POS_LAST) begin
               hdr_idx   = '0;
               body_left = blk_size - SIZE_BIAS;
               if (body_left == 0)
                  close_block(o);
               else
                  in_body = 1'b1;
            end else begin
               hdr_idx = hdr_idx + 5'd1;
            end
         end
      end
   endtask

   task deframe_byte(input req_type r, output rsp_type o);
      o = '0;
      if (r.cmd == CMD_RESTART) begin
         clear_framing();
         pts_now     = r.new_pts;
         o.byte_kind = KIND_NONE;
      end else begin
         o.byte_out = r.data_byte;
         if (sticky_err != ERR_NONE) begin
            o.byte_kind = KIND_NONE;
         end else if (in_body) begin
            o.byte_kind = KIND_PAYLOAD;
            body_left   = body_left - 32'd1;
            if (body_left == 0) begin
               in_body = 1'b0;
               close_block(o);
            end
         end else begin
            take_header_byte(r.data_byte, o);
         end
         o.error = sticky_err;
      end
   endtask

   task compare_result(input rsp_type got, input rsp_type want);
      if (got.byte_out !== want.byte_out)
         report_mismatch("byte_out", 64'(got.byte_out), 64'(want.byte_out));
      if (got.byte_kind !== want.byte_kind)
         report_mismatch("byte_kind", 64'(got.byte_kind), 64'(want.byte_kind));
      if (got.packet_start !== want.packet_start)
         report_mismatch("packet_start", 64'(got.packet_start), 64'(want.packet_start));
      if (got.packet_end !== want.packet_end)
         report_mismatch("packet_end", 64'(got.packet_end), 64'(want.packet_end));
      if (got.packet_pts !== want.packet_pts)
         report_mismatch("packet_pts", 64'(got.packet_pts), 64'(want.packet_pts));
      if (got.packet_duration !== want.packet_duration)
         report_mismatch("packet_duration", 64'(got.packet_duration),
                         64'(want.packet_duration));
      if (got.sample_rate !== want.sample_rate)
         report_mismatch("sample_rate", 64'(got.sample_rate), 64'(want.sample_rate));
      if (got.sample_bits !== want.sample_bits)
         report_mismatch("sample_bits", 64'(got.sample_bits), 64'(want.sample_bits));
      if (got.channel_total !== want.channel_total)
         report_mismatch("channel_total", 64'(got.channel_total), 64'(want.channel_total));
      if (got.error !== want.error)
         report_mismatch("error", 64'(got.error), 64'(want.error));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_framing();
         pts_now = '0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected transfer, byte_out", 64'(rsp_data.byte_out), 64'd0);
            end else begin
               oldest = expected_rsp.pop_front();
               compare_result(rsp_data, oldest);
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_data, predicted);
            expected_rsp.push_back(predicted);
         end
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench
   import wbd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] SYNC_WORD = 32'h6b70_7677;
   localparam int CYCLE_LIMIT = 800000;
   localparam int HOLD_CYCLES = 64;
   localparam int RANDOM_XFERS = 1800;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   logic        quiet = 1'b0;
   logic        hold_req = 1'b0;
   int unsigned xfer_count = 0;

   wavpack_block_deframer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   wbd_deframe_checker watch (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [47:0] rand_pts();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [31:0] pick_flags(input logic last);
      logic [31:0] f;
      f = $urandom;
      f[FINAL_BIT] = last;
      return f;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      xfer_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_type item;
      item.cmd       = CMD_BYTE;
      item.data_byte = b;
      item.new_pts   = rand_pts();
      send_item(item);
   endtask

   task automatic send_restart(input logic [47:0] pts);
      req_type item;
      item.cmd       = CMD_RESTART;
      item.data_byte = 8'($urandom);
      item.new_pts   = pts;
      send_item(item);
   endtask

   // cut < 0 sends the whole block, otherwise at most its first cut bytes
   task automatic send_block(input logic [31:0] size, input logic [31:0] flags,
                             input logic [31:0] samples, input logic [31:0] sync,
                             input int cut);
      logic [7:0] hdr [32];
      int total;
      for (int i = 0; i < 32; i++)
         hdr[i] = 8'($urandom);
      for (int i = 0; i < 4; i++) begin
         hdr[i]      = sync[8*i +: 8];
         hdr[4 + i]  = size[8*i +: 8];
         hdr[20 + i] = samples[8*i +: 8];
         hdr[24 + i] = flags[8*i +: 8];
      end
      total = (size >= SIZE_BIAS) ? 32 + int'(size - SIZE_BIAS) : 32;
      if (cut >= 0 && cut < total)
         total = cut;
      for (int n = 0; n < total; n++)
         send_byte((n < 32) ? hdr[n] : 8'($urandom));
   endtask

   task automatic send_packet(input int nblocks, input int max_len);
      logic [31:0] sync;
      for (int b = 0; b < nblocks; b++) begin
         sync = (b > 0 && $urandom_range(0, 3) == 0) ? $urandom : SYNC_WORD;
         send_block(SIZE_BIAS + $urandom_range(0, max_len), pick_flags(b == nblocks - 1),
                    $urandom, sync, -1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         if (!quiet && $urandom_range(0, 7) > 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      int unsigned xfer_goal;
      int pick;
      int lane;
      logic [31:0] sync;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_restart(48'h0);
      send_block(SIZE_BIAS, (32'h1 << FINAL_BIT) | (32'h1 << MONO_BIT), 32'h0, SYNC_WORD, -1);
      send_block(SIZE_BIAS + 3, 32'h0780_0003, 32'hFFFF_FFFF, SYNC_WORD, -1);
      send_block(SIZE_BIAS + 1, 32'hFFFF_FFFF, 32'h0, SYNC_WORD, -1);
      send_restart(48'hFFFF_FFFF_FFFF);
      send_packet(1, 4);
      send_packet(2, 0);
      drain();
      for (int k = 0; k < 4; k++) begin
         send_block(SIZE_BIAS, pick_flags(1'b1), $urandom, SYNC_WORD ^ (32'hFF << (8 * k)),
                    k + 4);
         send_restart(rand_pts());
      end
      send_block(SIZE_BIAS - 1, pick_flags(1'b1), $urandom, SYNC_WORD, 12);
      send_restart(rand_pts());
      send_block(32'd0, pick_flags(1'b1), $urandom, SYNC_WORD, 10);
      send_restart(rand_pts());
      send_block(SIZE_BIAS + 2, pick_flags(1'b0), $urandom, SYNC_WORD, -1);
      send_block(32'd7, pick_flags(1'b1), $urandom, SYNC_WORD, 12);
      send_restart(rand_pts());
      send_block(SIZE_BIAS + 2, pick_flags(1'b0), $urandom, SYNC_WORD, -1);
      send_block(SIZE_BIAS + 1, pick_flags(1'b1), $urandom, 32'h0, -1);
      drain();

      quiet = 1'b1;
      for (int b = 0; b < 130; b++)
         send_block(SIZE_BIAS, pick_flags(b == 129) & ~(32'h1 << MONO_BIT), $urandom,
                    SYNC_WORD, -1);
      hold_req = 1'b1;
      send_packet(3, 8);
      quiet = 1'b0;
      drain();

      xfer_goal = xfer_count + RANDOM_XFERS;
      while (xfer_count < xfer_goal) begin
         quiet = ($urandom_range(0, 7) == 0);
         pick  = $urandom_range(0, 99);
         if (pick < 70) begin
            send_packet($urandom_range(1, 4), ($urandom_range(0, 19) == 0) ? 300 : 12);
         end else if (pick < 76) begin
            send_restart(rand_pts());
         end else if (pick < 82) begin
            lane = $urandom_range(0, 3);
            sync = SYNC_WORD ^ (32'($urandom_range(1, 255)) << (8 * lane));
            send_block(SIZE_BIAS + $urandom_range(0, 12), pick_flags(1'b1), $urandom, sync,
                       $urandom_range(lane + 1, 40));
            send_restart(rand_pts());
         end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 1)
               send_block(SIZE_BIAS + $urandom_range(0, 8), pick_flags(1'b0), $urandom,
                          SYNC_WORD, -1);
            send_block($urandom_range(0, 23), pick_flags(1'($urandom_range(0, 1))), $urandom,
                       SYNC_WORD, $urandom_range(8, 40));
            send_restart(rand_pts());
         end else if (pick < 93) begin
            send_block(SIZE_BIAS + $urandom_range(0, 20),
                       pick_flags(1'($urandom_range(0, 1))),
                       $urandom, SYNC_WORD, $urandom_range(1, 50));
            send_restart(rand_pts());
         end else if (pick < 96) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            send_restart(rand_pts());
         end else if (pick < 98) begin
            quiet    = 1'b1;
            hold_req = 1'b1;
            send_packet(3, 8);
         end else begin
            drain();
         end
      end
      quiet = 1'b0;

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/wbd_pkg.sv
hw/rtl/wavpack_block_deframer.sv
verif/wbd_deframe_checker.sv
verif/testbench.sv
